@@ src/fwsc_pkg.sv @@
package fwsc_pkg;

   localparam int unsigned BYTE_BITS = 8;
   localparam int unsigned WORD_BITS = 2 * BYTE_BITS;
   localparam int unsigned INDEX_BITS = WORD_BITS + 1;

   typedef logic [BYTE_BITS-1:0]  byte_type;
   typedef logic [WORD_BITS-1:0]  word_type;
   typedef logic [INDEX_BITS-1:0] index_type;
   typedef logic [2:0]            status_type;

   localparam word_type   RESET_MAX_FRAME = 16'd1544;
   localparam index_type  HEADER_EXTRA    = 17'd6;
   localparam index_type  LENGTH_LOW_IDX  = 17'd2;
   localparam index_type  LENGTH_HIGH_IDX = 17'd3;

   localparam status_type ST_BUSY     = 3'd0;
   localparam status_type ST_PASS     = 3'd1;
   localparam status_type ST_MISMATCH = 3'd2;
   localparam status_type ST_TOO_LONG = 3'd3;
   localparam status_type ST_ODD      = 3'd4;

   typedef struct packed {
      byte_type data_byte;
      logic     frame_start;
   } req_type;

   typedef struct packed {
      byte_type   out_byte;
      logic       frame_done;
      status_type status;
   } rsp_type;

endpackage

@@ src/fwsc_channels.sv @@
interface fwsc_req_if;
   logic              valid;
   logic              ready;
   fwsc_pkg::byte_type data_byte;
   logic              frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink   (input valid, input data_byte, input frame_start, output ready);
endinterface

interface fwsc_rsp_if;
   logic                 valid;
   logic                 ready;
   fwsc_pkg::byte_type   out_byte;
   logic                 frame_done;
   fwsc_pkg::status_type status;

   modport source (output valid, output out_byte, output frame_done, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input frame_done, input status,
                   output ready);
endinterface

interface fwsc_csr_if;
   logic               valid;
   logic               ready;
   fwsc_pkg::word_type max_frame_bytes;

   modport source (output valid, output max_frame_bytes, input ready);
   modport sink   (input valid, input max_frame_bytes, output ready);
endinterface

@@ src/fwsc_check.sv @@
module fwsc_check (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  fwsc_pkg::req_type  item,
   input  fwsc_pkg::word_type max_frame_bytes,
   output logic               emit,
   output fwsc_pkg::rsp_type  result
);
   import fwsc_pkg::*;

   logic      in_frame_ff, in_frame_in;
   index_type byte_index_ff, byte_index_in;
   index_type frame_length_ff, frame_length_in;
   byte_type  length_low_ff, length_low_in;
   byte_type  word_low_ff, word_low_in;
   word_type  running_sum_ff, running_sum_in;

   index_type  idx;
   index_type  flen;
   byte_type   llow;
   byte_type   wlow;
   word_type   sum;
   word_type   word;
   index_type  new_length;
   logic       at_length;
   logic       last_word;
   logic       too_long;
   logic       odd_length;
   logic       done;
   status_type status;

   always_comb begin
      idx  = item.frame_start ? '0 : byte_index_ff;
      flen = item.frame_start ? '0 : frame_length_ff;
      llow = item.frame_start ? '0 : length_low_ff;
      wlow = item.frame_start ? '0 : word_low_ff;
      sum  = item.frame_start ? '0 : running_sum_ff;

      emit = item.frame_start | in_frame_ff;
      word = {item.data_byte, wlow};

      last_word = idx[0] && (idx >= LENGTH_HIGH_IDX) &&
                  (({1'b0, idx} + 18'd1) == {1'b0, flen});

      at_length  = (idx == LENGTH_HIGH_IDX);
      new_length = {1'b0, item.data_byte, llow} + HEADER_EXTRA;
      too_long   = new_length > {1'b0, max_frame_bytes};
      odd_length = new_length[0];

      done   = last_word || (at_length && (too_long || odd_length));
      status = ST_BUSY;
      if (last_word) begin
         status = (word == sum) ? ST_PASS : ST_MISMATCH;
      end
      if (at_length && too_long) begin
         status = ST_TOO_LONG;
      end else if (at_length && odd_length) begin
         status = ST_ODD;
      end

      length_low_in   = (idx == LENGTH_LOW_IDX) ? item.data_byte : llow;
      word_low_in     = idx[0] ? wlow : item.data_byte;
      running_sum_in  = (idx[0] && !last_word) ? sum + word : sum;
      frame_length_in = at_length ? new_length : flen;
      in_frame_in     = !done;
      byte_index_in   = done ? idx : idx + 17'd1;

      result.out_byte   = item.data_byte;
      result.frame_done = done;
      result.status     = status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_frame_ff     <= 1'b0;
         byte_index_ff   <= '0;
         frame_length_ff <= '0;
         length_low_ff   <= '0;
         word_low_ff     <= '0;
         running_sum_ff  <= '0;
      end else if (step && emit) begin
         in_frame_ff     <= in_frame_in;
         byte_index_ff   <= byte_index_in;
         frame_length_ff <= frame_length_in;
         length_low_ff   <= length_low_in;
         word_low_ff     <= word_low_in;
         running_sum_ff  <= running_sum_in;
      end
   end

endmodule

@@ src/frame_word_sum_checker.sv @@
// Frame word-sum checker. Takes one frame byte per clock on req, restarting at any
// byte marked frame_start, and forwards every byte of an open frame on rsp; the last
// byte of a frame carries frame_done and the status (pass, checksum mismatch, too long
// or odd length). Bytes outside a frame are dropped without a word on rsp. Sustained
// rate is one byte per clock while rsp is not stalled; a byte passes through an input
// and a result register with the length and word-sum compare between them. The user
// writes max_frame_bytes on csr while no frame is in flight; the block does not check.
module frame_word_sum_checker (
   input  logic        clock,
   input  logic        reset,
   fwsc_req_if.sink    req,
   fwsc_rsp_if.source  rsp,
   fwsc_csr_if.sink    csr
);
   import fwsc_pkg::*;

   logic     req_valid_ff;
   req_type  req_data_ff;
   logic     rsp_valid_ff, rsp_valid_in;
   rsp_type  rsp_data_ff;
   word_type max_frame_ff;

   logic     advance;
   logic     emit;
   rsp_type  result;

   assign advance   = !rsp_valid_ff || rsp.ready;
   assign req.ready = !req_valid_ff || advance;
   assign csr.ready = 1'b1;

   assign rsp_valid_in = req_valid_ff && emit;

   fwsc_check u_check (
      .clock           (clock),
      .reset           (reset),
      .step            (advance && req_valid_ff),
      .item            (req_data_ff),
      .max_frame_bytes (max_frame_ff),
      .emit            (emit),
      .result          (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         max_frame_ff <= RESET_MAX_FRAME;
      end else begin
         if (req.ready) begin
            req_valid_ff <= req.valid;
         end
         if (advance) begin
            rsp_valid_ff <= rsp_valid_in;
         end
         if (csr.valid) begin
            max_frame_ff <= csr.max_frame_bytes;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         req_data_ff.data_byte   <= req.data_byte;
         req_data_ff.frame_start <= req.frame_start;
      end
      if (advance && rsp_valid_in) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.out_byte   = rsp_data_ff.out_byte;
   assign rsp.frame_done = rsp_data_ff.frame_done;
   assign rsp.status     = rsp_data_ff.status;

   a_busy_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.frame_done |-> rsp_data_ff.status == ST_BUSY)
      else $error("status set on a word that does not end a frame");

   a_done_status : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.frame_done |->
         rsp_data_ff.status == ST_PASS || rsp_data_ff.status == ST_MISMATCH ||
         rsp_data_ff.status == ST_TOO_LONG || rsp_data_ff.status == ST_ODD)
      else $error("frame ended without a final status");

   a_hold_input : assert property (@(posedge clock) disable iff (reset)
      req_valid_ff && !advance |=> req_valid_ff && $stable(req_data_ff))
      else $error("input word lost while result stage stalled");

endmodule

@@ tb/tb_frame_word_sum_checker.sv @@
`timescale 1ns / 100ps

module tb_frame_word_sum_checker;
   import fwsc_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 7;
   localparam int DRAIN_CYCLES  = 6;
   localparam int QUIET_LIMIT   = 4000;
   localparam int HOLD_CYCLES   = 400;
   localparam int PHASE_RESULTS = 200;
   localparam int REPORT_LIMIT  = 10;

   class frame_sum_scoreboard;
      rsp_type     forwarded_q[$];
      word_type    max_frame;
      logic        in_frame;
      index_type   byte_index;
      index_type   frame_length;
      byte_type    length_low;
      byte_type    word_low;
      word_type    running_sum;
      int unsigned mismatches;

      function new();
         max_frame    = RESET_MAX_FRAME;
         in_frame     = 1'b0;
         byte_index   = '0;
         frame_length = '0;
         length_low   = '0;
         word_low     = '0;
         running_sum  = '0;
         mismatches   = 0;
      endfunction

      function void set_limit(word_type value);
         max_frame = value;
      endfunction

      function int pending();
         return forwarded_q.size();
      endfunction

      function bit note_byte(byte_type data, logic start);
         word_type   word;
         rsp_type    item;
         status_type st;
         logic       done;
         st   = ST_BUSY;
         done = 1'b0;
         if (start) begin
            in_frame     = 1'b1;
            byte_index   = '0;
            frame_length = '0;
            length_low   = '0;
            word_low     = '0;
            running_sum  = '0;
         end else if (!in_frame) begin
            return 1'b0;
         end
         if (byte_index == LENGTH_LOW_IDX) length_low = data;
         if (!byte_index[0]) begin
            word_low = data;
         end else begin
            word = {data, word_low};
            if (byte_index >= LENGTH_HIGH_IDX &&
                byte_index + index_type'(1) == frame_length) begin
               st   = (word == running_sum) ? ST_PASS : ST_MISMATCH;
               done = 1'b1;
            end else begin
               running_sum = running_sum + word;
            end
         end
         if (byte_index == LENGTH_HIGH_IDX) begin
            frame_length = index_type'({data, length_low}) + HEADER_EXTRA;
            if (frame_length > index_type'(max_frame)) begin
               st   = ST_TOO_LONG;
               done = 1'b1;
            end else if (frame_length[0]) begin
               st   = ST_ODD;
               done = 1'b1;
            end
         end
         if (done) in_frame = 1'b0;
         else byte_index = byte_index + index_type'(1);
         item.out_byte   = data;
         item.frame_done = done;
         item.status     = st;
         forwarded_q.push_back(item);
         return 1'b1;
      endfunction

      function void check_word(byte_type got_byte, logic got_done, status_type got_status);
         rsp_type want;
         if (forwarded_q.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("unexpected rsp word: byte %h done %b status %0d",
                        got_byte, got_done, got_status);
            return;
         end
         want = forwarded_q.pop_front();
         if (want.out_byte !== got_byte || want.frame_done !== got_done ||
             want.status !== got_status) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display({"rsp mismatch: expected byte %h done %b status %0d, ",
                         "got byte %h done %b status %0d"},
                        want.out_byte, want.frame_done, want.status,
                        got_byte, got_done, got_status);
         end
      endfunction
   endclass

   logic clock;
   logic reset;

   fwsc_req_if req_ch ();
   fwsc_rsp_if rsp_ch ();
   fwsc_csr_if csr_ch ();

   frame_word_sum_checker dut (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch),
      .csr   (csr_ch)
   );

   frame_sum_scoreboard sb;
   int unsigned results_sent = 0;
   int unsigned cur_limit    = int'(RESET_MAX_FRAME);
   int unsigned quiet_cycles = 0;
   int unsigned hold_left    = 0;
   bit          idle_on      = 1'b1;
   bit          hold_request = 1'b0;

   initial clock = 1'b0;
   always #(CLK_PERIOD / 2) clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready)
         sb.check_word(rsp_ch.out_byte, rsp_ch.frame_done, rsp_ch.status);
   end

   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
          (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // hold off the result side on request so the block backs up into req
   initial begin
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left != 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= !(idle_on && $urandom_range(99) < 12);
         end
      end
   end

   task automatic send_byte(byte_type data, logic start);
      if (idle_on && $urandom_range(99) < 12) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.data_byte   <= data;
      req_ch.frame_start <= start;
      do @(posedge clock); while (!req_ch.ready);
      results_sent += int'(sb.note_byte(data, start));
   endtask

   task automatic send_packed(logic [47:0] bytes, int unsigned count);
      for (int unsigned i = 0; i < count; i++) send_byte(bytes[8*i +: 8], i == 0);
   endtask

   task automatic send_frame(int unsigned payload, bit corrupt, bit abandon);
      byte_type    frame_q[$];
      int unsigned total;
      int unsigned n_send;
      word_type    sum;
      word_type    last;
      total = payload + 6;
      frame_q.push_back(byte_type'($urandom_range(0, 255)));
      frame_q.push_back(byte_type'($urandom_range(0, 255)));
      frame_q.push_back(payload[7:0]);
      frame_q.push_back(payload[15:8]);
      if (total > cur_limit || total[0]) begin
         n_send = 4;
      end else begin
         for (int unsigned i = 4; i < total - 2; i++)
            frame_q.push_back(byte_type'($urandom_range(0, 255)));
         sum = '0;
         for (int unsigned i = 0; i < total - 2; i += 2) sum += {frame_q[i+1], frame_q[i]};
         last = corrupt ? sum ^ word_type'($urandom_range(1, 65535)) : sum;
         frame_q.push_back(last[7:0]);
         frame_q.push_back(last[15:8]);
         n_send = total;
      end
      if (abandon) n_send = $urandom_range(1, n_send - 1);
      for (int unsigned i = 0; i < n_send; i++) send_byte(frame_q[i], i == 0);
      if (!abandon && $urandom_range(99) < 20)
         repeat ($urandom_range(1, 3)) send_byte(byte_type'($urandom_range(0, 255)), 1'b0);
   endtask

   function automatic int unsigned pick_payload();
      int unsigned pick;
      int unsigned value;
      pick = $urandom_range(99);
      if (pick < 65) return $urandom_range(0, 30);
      if (pick < 85) begin
         if (cur_limit > 300) return $urandom_range(0, 60);
         value = cur_limit - 6 + $urandom_range(0, 3);
         return (value >= 2) ? value - 2 : 0;
      end
      value = $urandom_range(0, 65535);
      // keep accepted frames short: force odd length on long ones
      if (value + 6 <= cur_limit && value > 300) value = value | 1;
      return value;
   endfunction

   task automatic run_random_frames(int unsigned goal);
      int unsigned first;
      int unsigned pick;
      first = results_sent;
      while (results_sent - first < goal) begin
         pick = $urandom_range(99);
         if (pick < 8) send_byte(byte_type'($urandom_range(0, 255)), 1'b0);
         else send_frame(pick_payload(), pick < 20, pick >= 90);
      end
   endtask

   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_frame(int unsigned value);
      drain_pipeline();
      csr_ch.valid           <= 1'b1;
      csr_ch.max_frame_bytes <= word_type'(value);
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      sb.set_limit(word_type'(value));
      cur_limit = value;
   endtask

   initial begin
      sb = new();
      reset                  <= 1'b1;
      req_ch.valid           <= 1'b0;
      req_ch.data_byte       <= '0;
      req_ch.frame_start     <= 1'b0;
      csr_ch.valid           <= 1'b0;
      csr_ch.max_frame_bytes <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      send_byte(8'hA5, 1'b0);
      send_packed(48'hFFFF_0000_FFFF, 6);
      send_packed(48'h0100_0000_0000, 6);
      send_packed(48'h0000_0000_C35A, 2);
      send_packed(48'h0000_0001_813C, 4);
      send_packed(48'h0000_FFFF_FFFF, 4);
      send_byte(8'h7E, 1'b0);
      run_random_frames(PHASE_RESULTS);

      write_max_frame(6);
      run_random_frames(PHASE_RESULTS);

      write_max_frame($urandom_range(7, 120));
      run_random_frames(PHASE_RESULTS / 2);
      hold_request = 1'b1;
      run_random_frames(PHASE_RESULTS / 2);

      write_max_frame(65535);
      idle_on = 1'b0;
      send_frame(65529, 1'b0, 1'b0);
      send_frame(65530, 1'b0, 1'b0);
      run_random_frames(PHASE_RESULTS);
      idle_on = 1'b1;

      write_max_frame($urandom_range(6, 65535));
      run_random_frames(PHASE_RESULTS);

      write_max_frame(RESET_MAX_FRAME);
      run_random_frames(PHASE_RESULTS);

      drain_pipeline();
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/fwsc_pkg.sv
src/fwsc_channels.sv
src/fwsc_check.sv
src/frame_word_sum_checker.sv
tb/tb_frame_word_sum_checker.sv
